/* hdl/fqp_pkg.sv */
`default_nettype none

package fqp_pkg;

    localparam int FQP_MAX_READ_LEN = 1024;
    localparam int FQP_MAX_NAME_LEN = 256;

    // result slots filled by one input byte
    localparam int RES_SLOTS = 2;

    // configuration register indexes
    localparam logic CFG_COLOR_SPACE = 1'b0;
    localparam logic CFG_TRIM_PRIMER = 1'b1;

    // characters
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        KIND_NAME       = 3'd0,
        KIND_BASE       = 3'd1,
        KIND_QUAL       = 3'd2,
        KIND_BASES_DONE = 3'd3,
        KIND_REC_END    = 3'd4,
        KIND_STREAM_END = 3'd5,
        KIND_ERROR      = 3'd6
    } fqp_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_INCOMPLETE = 3'd1,
        ERR_BAD_BASE   = 3'd2,
        ERR_MISMATCH   = 3'd3,
        ERR_TOO_LONG   = 3'd4
    } fqp_err_t;

    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_NAME    = 3'd1,
        PH_BASES   = 3'd2,
        PH_COMMENT = 3'd3,
        PH_QUAL    = 3'd4,
        PH_QSKIP   = 3'd5
    } fqp_phase_t;

    typedef struct packed {
        logic color_space;
        logic trim_primer;
    } fqp_cfg_t;

    typedef struct packed {
        fqp_kind_t   kind;
        logic [7:0]  out_value;
        logic [9:0]  position;
        logic [10:0] item_count;
        logic        trimmed;
        logic [11:0] qual_shift;
        fqp_err_t    error_code;
        logic        last;
    } fqp_result_t;

    function automatic fqp_result_t mk_result(
        input fqp_kind_t   kind,
        input logic [7:0]  value,
        input logic [9:0]  pos,
        input logic [10:0] count,
        input logic        trim,
        input logic [11:0] shift,
        input fqp_err_t    err
    );
        fqp_result_t r;
        r.kind       = kind;
        r.out_value  = value;
        r.position   = pos;
        r.item_count = count;
        r.trimmed    = trim;
        r.qual_shift = shift;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic fqp_result_t mk_error(input fqp_err_t err);
        return mk_result(KIND_ERROR, 8'd0, 10'd0, 11'd0, 1'b0, 12'd0, err);
    endfunction

    // A0 C1 G2 T3, other letters 4; idx is the letter's place from 1
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd1:    c = 8'd0;
            5'd3:    c = 8'd1;
            5'd7:    c = 8'd2;
            5'd20:   c = 8'd3;
            default: c = 8'd4;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/fastq_record_parser.sv */
// Channel  | Ports                          | Contents
// ---------+--------------------------------+------------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | one FASTQ text byte or end of data
// result   | m_tvalid m_tready m_tdata m_tuser m_tlast | name byte, base, quality, summaries
// config   | cfg_we cfg_index cfg_wdata     | color_space (0), trim_primer (1)
//
// A byte is parsed while it sits in the input register and the result buffer is free; its
// results sit in a two-entry result buffer. Bytes flow at one per cycle while m_tready
// holds high; a byte that yields two results holds the parser while the buffer drains.
// aresetn is synchronous; it returns the parser to header search with all counts zero.
// A stalled result side backs up into the input register, then drops s_tready.
`default_nettype none

module fastq_record_parser import fqp_pkg::*; #(
    parameter int MAX_READ_LEN = FQP_MAX_READ_LEN,
    parameter int MAX_NAME_LEN = FQP_MAX_NAME_LEN
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] end_of_data

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_value, [17:8] position, [28:18] item_count, [29] trimmed,
    // [41:30] qual_shift, [44:42] error_code, [47:45] zero
    output logic [47:0]      m_tdata,
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wdata
);

    fqp_cfg_t                    cfg_reg;
    logic                        in_valid_reg, in_valid_next;
    logic [7:0]                  in_byte_reg;
    logic                        in_eod_reg;
    logic                        s_accept;
    logic                        fire;
    logic                        buf_free;
    fqp_result_t [RES_SLOTS-1:0] core_results;
    logic [1:0]                  core_cnt;
    fqp_result_t                 out_result;

    assign fire          = in_valid_reg && buf_free;
    assign s_tready      = !in_valid_reg || fire;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cfg_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COLOR_SPACE: cfg_reg.color_space <= cfg_wdata;
                    CFG_TRIM_PRIMER: cfg_reg.trim_primer <= cfg_wdata;
                    default:         cfg_reg <= cfg_reg;
                endcase
            end
        end
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eod_reg  <= s_tuser;
        end
    end

    fqp_parse_core #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .fire        (fire),
        .in_byte     (in_byte_reg),
        .end_of_data (in_eod_reg),
        .results     (core_results),
        .result_cnt  (core_cnt)
    );

    fqp_out_buffer u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (fire),
        .load_results (core_results),
        .load_cnt     (core_cnt),
        .free         (buf_free),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (out_result)
    );

    assign m_tdata = {3'b000, out_result.error_code, out_result.qual_shift,
                      out_result.trimmed, out_result.item_count, out_result.position,
                      out_result.out_value};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

endmodule

`default_nettype wire

/* hdl/fqp_parse_core.sv */
`default_nettype none

module fqp_parse_core import fqp_pkg::*; #(
    parameter int MAX_READ_LEN = FQP_MAX_READ_LEN,
    parameter int MAX_NAME_LEN = FQP_MAX_NAME_LEN
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fqp_cfg_t                      cfg,
    input  wire logic                          fire,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          end_of_data,
    output fqp_result_t [RES_SLOTS-1:0]        results,
    output logic [1:0]                         result_cnt
);

    // counts hold up to one past the read limit (surplus colour-space quality)
    localparam int CW  = $clog2(MAX_READ_LEN + 2);
    localparam int NW  = $clog2(MAX_NAME_LEN + 1);
    localparam int AW  = (CW > 12) ? CW : 12;
    localparam int NAW = (NW > 10) ? NW : 10;

    fqp_phase_t      phase_reg, phase_next;
    logic [7:0]      held0_reg, held0_next;
    logic [7:0]      held1_reg, held1_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic [NW-1:0]   name_len_reg, name_len_next;
    logic [CW-1:0]   base_cnt_reg, base_cnt_next;
    logic [1:0]      primer_reg, primer_next;
    logic [CW-1:0]   read_len_reg, read_len_next;
    logic [CW-1:0]   qual_cnt_reg, qual_cnt_next;

    logic            is_upper, is_lower, is_letter, is_space, is_digit03;
    logic [7:0]      base_code;
    logic            trim;
    logic            drop;
    logic [CW-1:0]   read_len_trim;
    logic [AW-1:0]   base_x, rl_x, qc_x, qc1_x, rlt_x, close_shift, surplus_shift;
    logic [NAW-1:0]  nl_x, hc_x;
    logic [NAW-1:0]  pos_first, pos_second, pos_oldest;
    fqp_result_t     close_res;
    fqp_result_t     stream_end_res;
    logic [7:0]      name_val;

    always_comb begin
        is_upper   = (in_byte >= 8'h41) && (in_byte <= 8'h5A);
        is_lower   = (in_byte >= 8'h61) && (in_byte <= 8'h7A);
        is_letter  = is_upper || is_lower;
        is_digit03 = (in_byte >= CH_ZERO) && (in_byte <= CH_THREE);
        is_space   = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
        name_val   = is_space ? 8'd0 : in_byte;

        if (is_letter) begin
            base_code = letter_code(in_byte[4:0]);
        end else if (is_digit03) begin
            base_code = in_byte - CH_ZERO;
        end else begin
            base_code = 8'd4;
        end

        trim = cfg.trim_primer && (primer_reg == 2'd1) && (base_cnt_reg > CW'(1));
        read_len_trim = base_cnt_reg - CW'(trim);

        base_x = AW'(base_cnt_reg);
        rl_x   = AW'(read_len_reg);
        qc_x   = AW'(qual_cnt_reg);
        qc1_x  = qc_x + AW'(1);
        rlt_x  = AW'(read_len_trim);
        close_shift   = rl_x - qc_x;
        surplus_shift = rl_x - qc1_x;

        nl_x       = NAW'(name_len_reg);
        hc_x       = NAW'(held_cnt_reg);
        pos_first  = nl_x - hc_x;
        pos_second = nl_x - NAW'(1);
        pos_oldest = nl_x - NAW'(2);

        drop = (held_cnt_reg == 2'd2) && (name_len_reg > NW'(2)) &&
               (held0_reg == CH_SLASH) && ((held1_reg == CH_ONE) || (held1_reg == CH_TWO));

        if (cfg.color_space) begin
            close_res = mk_result(KIND_REC_END, 8'd0, 10'd0, qc_x[10:0], 1'b0,
                                  close_shift[11:0], ERR_NONE);
        end else if (qual_cnt_reg == read_len_reg) begin
            close_res = mk_result(KIND_REC_END, 8'd0, 10'd0, qc_x[10:0], 1'b0,
                                  12'd0, ERR_NONE);
        end else begin
            close_res = mk_error(ERR_MISMATCH);
        end
        stream_end_res = mk_result(KIND_STREAM_END, 8'd0, 10'd0, 11'd0, 1'b0, 12'd0,
                                   ERR_NONE);
    end

    always_comb begin
        phase_next    = phase_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        name_len_next = name_len_reg;
        base_cnt_next = base_cnt_reg;
        primer_next   = primer_reg;
        read_len_next = read_len_reg;
        qual_cnt_next = qual_cnt_reg;
        results       = '0;
        result_cnt    = 2'd0;

        case (phase_reg)
            PH_SEEK: begin
                if (end_of_data) begin
                    results[0] = stream_end_res;
                    result_cnt = 2'd1;
                end else if (in_byte == CH_AT) begin
                    phase_next    = PH_NAME;
                    name_len_next = '0;
                    held_cnt_next = 2'd0;
                end
            end
            PH_NAME: begin
                if (end_of_data) begin
                    results[0] = mk_error(ERR_INCOMPLETE);
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if (in_byte == CH_LF) begin
                    // flush the held tail unless it is a /1 or /2 mate suffix
                    results[0] = mk_result(KIND_NAME, held0_reg, pos_first[9:0], 11'd0,
                                           1'b0, 12'd0, ERR_NONE);
                    results[1] = mk_result(KIND_NAME, held1_reg, pos_second[9:0], 11'd0,
                                           1'b0, 12'd0, ERR_NONE);
                    result_cnt    = drop ? 2'd0 : held_cnt_reg;
                    held_cnt_next = 2'd0;
                    phase_next    = PH_BASES;
                    base_cnt_next = '0;
                    primer_next   = 2'd0;
                end else if (name_len_reg >= NW'(MAX_NAME_LEN)) begin
                    results[0]    = mk_error(ERR_TOO_LONG);
                    result_cnt    = 2'd1;
                    held_cnt_next = 2'd0;
                    phase_next    = PH_SEEK;
                end else begin
                    case (held_cnt_reg)
                        2'd0: begin
                            held0_next    = name_val;
                            held_cnt_next = 2'd1;
                        end
                        2'd1: begin
                            held1_next    = name_val;
                            held_cnt_next = 2'd2;
                        end
                        default: begin
                            results[0] = mk_result(KIND_NAME, held0_reg, pos_oldest[9:0],
                                                   11'd0, 1'b0, 12'd0, ERR_NONE);
                            result_cnt = 2'd1;
                            held0_next = held1_reg;
                            held1_next = name_val;
                        end
                    endcase
                    name_len_next = name_len_reg + NW'(1);
                end
            end
            PH_BASES: begin
                if (end_of_data) begin
                    results[0] = mk_error(ERR_INCOMPLETE);
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if ((in_byte == CH_CR) || (in_byte == CH_LF)) begin
                    phase_next = PH_BASES;
                end else if (in_byte == CH_PLUS) begin
                    read_len_next = read_len_trim;
                    results[0] = mk_result(KIND_BASES_DONE, 8'd0, 10'd0, rlt_x[10:0], trim,
                                           12'd0, ERR_NONE);
                    result_cnt = 2'd1;
                    phase_next = PH_COMMENT;
                end else if (!is_letter && !cfg.color_space) begin
                    results[0] = mk_error(ERR_BAD_BASE);
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if (base_cnt_reg >= CW'(MAX_READ_LEN)) begin
                    results[0] = mk_error(ERR_TOO_LONG);
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else begin
                    if (cfg.color_space && is_letter && (primer_reg < 2'd2)) begin
                        primer_next = primer_reg + 2'd1;
                    end
                    results[0] = mk_result(KIND_BASE, base_code, base_x[9:0], 11'd0, 1'b0,
                                           12'd0, ERR_NONE);
                    result_cnt    = 2'd1;
                    base_cnt_next = base_cnt_reg + CW'(1);
                end
            end
            PH_COMMENT: begin
                if (end_of_data) begin
                    results[0] = mk_error(ERR_INCOMPLETE);
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if (in_byte == CH_LF) begin
                    qual_cnt_next = '0;
                    phase_next    = PH_QUAL;
                end
            end
            PH_QUAL: begin
                if (end_of_data) begin
                    results[0] = close_res;
                    results[1] = stream_end_res;
                    result_cnt = 2'd2;
                    phase_next = PH_SEEK;
                end else if (in_byte == CH_LF) begin
                    results[0] = close_res;
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if ((in_byte >= CH_BANG) && (in_byte <= CH_DEL)) begin
                    if (qual_cnt_reg >= read_len_reg) begin
                        // surplus: colour-space close or mismatch; skip the rest
                        if (cfg.color_space) begin
                            results[0] = mk_result(KIND_QUAL, in_byte, qc_x[9:0], 11'd0, 1'b0,
                                                   12'd0, ERR_NONE);
                            results[1] = mk_result(KIND_REC_END, 8'd0, 10'd0, qc1_x[10:0],
                                                   1'b0, surplus_shift[11:0], ERR_NONE);
                            result_cnt    = 2'd2;
                            qual_cnt_next = qual_cnt_reg + CW'(1);
                        end else begin
                            results[0] = mk_error(ERR_MISMATCH);
                            result_cnt = 2'd1;
                        end
                        phase_next = PH_QSKIP;
                    end else begin
                        results[0] = mk_result(KIND_QUAL, in_byte, qc_x[9:0], 11'd0, 1'b0,
                                               12'd0, ERR_NONE);
                        result_cnt    = 2'd1;
                        qual_cnt_next = qual_cnt_reg + CW'(1);
                    end
                end
            end
            PH_QSKIP: begin
                if (end_of_data) begin
                    results[0] = stream_end_res;
                    result_cnt = 2'd1;
                    phase_next = PH_SEEK;
                end else if (in_byte == CH_LF) begin
                    phase_next = PH_SEEK;
                end
            end
            default: begin
                phase_next = PH_SEEK;
            end
        endcase

        case (result_cnt)
            2'd1:    results[0].last = 1'b1;
            2'd2:    results[1].last = 1'b1;
            default: results[0].last = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEEK;
            held0_reg    <= '0;
            held1_reg    <= '0;
            held_cnt_reg <= '0;
            name_len_reg <= '0;
            base_cnt_reg <= '0;
            primer_reg   <= '0;
            read_len_reg <= '0;
            qual_cnt_reg <= '0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            held_cnt_reg <= held_cnt_next;
            name_len_reg <= name_len_next;
            base_cnt_reg <= base_cnt_next;
            primer_reg   <= primer_next;
            read_len_reg <= read_len_next;
            qual_cnt_reg <= qual_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/fqp_out_buffer.sv */
`default_nettype none

module fqp_out_buffer import fqp_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire fqp_result_t [RES_SLOTS-1:0] load_results,
    input  wire logic [1:0]                 load_cnt,
    output logic                            free,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output fqp_result_t                     out_result
);

    fqp_result_t [RES_SLOTS-1:0] slot_reg, slot_next;
    logic [1:0]                  rem_reg, rem_next;
    logic                        head_reg, head_next;
    logic                        pop;

    always_comb begin
        out_valid  = (rem_reg != 2'd0);
        out_result = slot_reg[head_reg];
        pop        = out_valid && out_ready;
        // refill is allowed in the same cycle the final pending result leaves
        free       = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop);

        slot_next = slot_reg;
        rem_next  = rem_reg;
        head_next = head_reg;
        if (load && (load_cnt != 2'd0)) begin
            slot_next = load_results;
            rem_next  = load_cnt;
            head_next = 1'b0;
        end else if (pop) begin
            rem_next  = rem_reg - 2'd1;
            head_next = ~head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= 2'd0;
            head_reg <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            head_reg <= head_next;
        end
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire
